FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL top level; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: hdl/dqcl_pkg.sv
// ----------------------------------------------------------------------------
// dqcl_pkg
// Types, reset constants and helper functions of the code lock.
// ----------------------------------------------------------------------------
`default_nettype none

package dqcl_pkg;

    localparam int CODE_LENGTH_DEF = 4;

    localparam int MV_W    = 12;
    localparam int CNT_W   = 8;
    localparam int LEVEL_W = 3;
    localparam int RANGE_W = 2;
    localparam int TONE_W  = 11;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 12;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_CODE_WORD   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HOLD_COUNT  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_START_THR   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_UPPER_THR   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_LOWER_THR   = 3'd4;

    localparam logic [7:0]      CODE_WORD_RST  = 8'd121;
    localparam logic [CNT_W-1:0] HOLD_COUNT_RST = 8'd20;
    localparam logic [MV_W-1:0] START_THR_RST  = 12'd1000;
    localparam logic [MV_W-1:0] UPPER_THR_RST  = 12'd2000;
    localparam logic [MV_W-1:0] LOWER_THR_RST  = 12'd1200;

    localparam logic [RANGE_W-1:0] RANGE_HIGH = 2'd1;
    localparam logic [RANGE_W-1:0] RANGE_MID  = 2'd2;
    localparam logic [RANGE_W-1:0] RANGE_LOW  = 2'd3;

    localparam logic [TONE_W-1:0] TONE_HIGH = 11'd440;
    localparam logic [TONE_W-1:0] TONE_MID  = 11'd880;
    localparam logic [TONE_W-1:0] TONE_LOW  = 11'd1760;

    localparam logic [CNT_W-1:0] CNT_MAX       = 8'd255;
    localparam logic [CNT_W-1:0] START_TRIGGER = 8'd2;

    typedef struct packed {
        logic [7:0]       code_word;
        logic [CNT_W-1:0] hold_count;
        logic [MV_W-1:0]  start_thr;
        logic [MV_W-1:0]  upper_thr;
        logic [MV_W-1:0]  lower_thr;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_now;
        logic [TONE_W-1:0]  tone_hz;
    } class_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] led_level;
        logic               solenoid_on;
        logic               done;
    } status_t;

    function automatic logic [TONE_W-1:0] tone_for(input logic [RANGE_W-1:0] r);
        logic [TONE_W-1:0] t;
        case (r)
            RANGE_HIGH: t = TONE_HIGH;
            RANGE_MID:  t = TONE_MID;
            default:    t = TONE_LOW;
        endcase
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c < CNT_MAX) ? c + 8'd1 : CNT_MAX;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dwell_qualified_code_lock_top.sv
// ----------------------------------------------------------------------------
// dwell_qualified_code_lock_top
// Code lock driven by dwell on voltage ranges, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   s_        in         s_valid/s_ready    s_sample_mv
//   m_        out        m_valid/m_ready    m_range_now, m_tone_hz, m_led_level,
//                                           m_solenoid_on, m_done_res
//   cfg_      in         cfg_wen            cfg_addr, cfg_wdata
//
// Takes one word every cycle unless the output stalls. An accepted word sits
// in the input register, is judged by the classifier and core, and moves into
// the output register when it advances; m_valid then rises. The classifier and
// the core state update form the combinational path between the two registers.
// Synchronous active-low reset clears the lock state and loads register
// defaults. A stalled output holds the input register; s_ready stays high
// while the input register is empty or its word can move on in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dwell_qualified_code_lock_top #(
    parameter int CODE_LENGTH = dqcl_pkg::CODE_LENGTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // sample word in
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [dqcl_pkg::MV_W-1:0]     s_sample_mv,
    // result word out
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dqcl_pkg::RANGE_W-1:0]       m_range_now,
    output logic [dqcl_pkg::TONE_W-1:0]        m_tone_hz,
    output logic [dqcl_pkg::LEVEL_W-1:0]       m_led_level,
    output logic                               m_solenoid_on,
    output logic                               m_done_res,
    // register writes
    input  wire logic                          cfg_wen,
    input  wire logic [dqcl_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [dqcl_pkg::CFG_DW-1:0]   cfg_wdata
);
    import dqcl_pkg::*;

    // ---------------- configuration registers ----------------
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_word  <= CODE_WORD_RST;
            cfg_reg.hold_count <= HOLD_COUNT_RST;
            cfg_reg.start_thr  <= START_THR_RST;
            cfg_reg.upper_thr  <= UPPER_THR_RST;
            cfg_reg.lower_thr  <= LOWER_THR_RST;
        end else if (cfg_wen) begin
            // unknown indexes fall through and are dropped
            case (cfg_addr)
                REG_CODE_WORD:  cfg_reg.code_word  <= cfg_wdata[7:0];
                REG_HOLD_COUNT: cfg_reg.hold_count <= cfg_wdata[CNT_W-1:0];
                REG_START_THR:  cfg_reg.start_thr  <= cfg_wdata[MV_W-1:0];
                REG_UPPER_THR:  cfg_reg.upper_thr  <= cfg_wdata[MV_W-1:0];
                REG_LOWER_THR:  cfg_reg.lower_thr  <= cfg_wdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic            in_valid_reg, in_valid_next;
    logic [MV_W-1:0] sample_reg;
    logic            out_valid_reg, out_valid_next;
    logic            advance;

    // move the held word on when the output slot is empty or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            sample_reg <= s_sample_mv;
        end
    end

    // ---------------- single-pass logic ----------------
    class_t  cls;
    status_t status_next;
    logic    core_finished;

    dqcl_classify u_classify (
        .sample_mv (sample_reg),
        .upper_thr (cfg_reg.upper_thr),
        .lower_thr (cfg_reg.lower_thr),
        .cls       (cls)
    );

    dqcl_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .sample_mv   (sample_reg),
        .range_now   (cls.range_now),
        .cfg         (cfg_reg),
        .status_next (status_next),
        .finished    (core_finished)
    );

    // ---------------- output register ----------------
    class_t  cls_reg;
    status_t status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cls_reg    <= cls;
            status_reg <= status_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_range_now   = cls_reg.range_now;
    assign m_tone_hz     = cls_reg.tone_hz;
    assign m_led_level   = status_reg.led_level;
    assign m_solenoid_on = status_reg.solenoid_on;
    assign m_done_res    = status_reg.done;

    // ---------------- checks ----------------
`include "assert_macros.svh"

    `ASSERT_IMPLY(a_done_level, aclk, aresetn, m_valid && m_done_res, m_led_level == LEVEL_W'(CODE_LENGTH))
    `ASSERT_IMPLY(a_range_valid, aclk, aresetn, m_valid, m_range_now != 2'd0)
    `ASSERT_NEXT(a_finish_sticks, aclk, aresetn, core_finished, core_finished)
    `ASSERT_IMPLY(a_full_stall, aclk, aresetn, in_valid_reg && out_valid_reg && !m_ready, !s_ready)

endmodule

`default_nettype wire

FILE: hdl/dqcl_classify.sv
// ----------------------------------------------------------------------------
// dqcl_classify
// Sorts one sample into a range by two thresholds and picks its tone.
// ----------------------------------------------------------------------------
`default_nettype none

module dqcl_classify (
    input  wire logic [dqcl_pkg::MV_W-1:0] sample_mv,
    input  wire logic [dqcl_pkg::MV_W-1:0] upper_thr,
    input  wire logic [dqcl_pkg::MV_W-1:0] lower_thr,
    output dqcl_pkg::class_t               cls
);
    import dqcl_pkg::*;

    logic [RANGE_W-1:0] range_w;

    // upper threshold wins when the two are crossed
    always_comb begin
        if (sample_mv >= upper_thr) begin
            range_w = RANGE_HIGH;
        end else if (sample_mv >= lower_thr) begin
            range_w = RANGE_MID;
        end else begin
            range_w = RANGE_LOW;
        end
    end

    assign cls.range_now = range_w;
    assign cls.tone_hz   = tone_for(range_w);

endmodule

`default_nettype wire

FILE: hdl/dqcl_core.sv
// ----------------------------------------------------------------------------
// dqcl_core
// Start detection, dwell counting and code judging for one sample per step.
// ----------------------------------------------------------------------------
`default_nettype none

module dqcl_core #(
    parameter int CODE_LENGTH = dqcl_pkg::CODE_LENGTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         step,
    input  wire logic [dqcl_pkg::MV_W-1:0]    sample_mv,
    input  wire logic [dqcl_pkg::RANGE_W-1:0] range_now,
    input  wire dqcl_pkg::cfg_t               cfg,
    output dqcl_pkg::status_t                 status_next,
    output logic                              finished
);
    import dqcl_pkg::*;

    localparam logic [LEVEL_W-1:0] LEVEL_DONE = LEVEL_W'(CODE_LENGTH);

    logic               started_reg, started_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RANGE_W-1:0] last_reg, last_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               sol_reg, sol_next;
    logic               fin_reg, fin_next;

    logic [RANGE_W-1:0] want;
    logic [LEVEL_W-1:0] level_inc;

    assign want      = cfg.code_word[{level_reg[1:0], 1'b0} +: RANGE_W];
    assign level_inc = level_reg + 3'd1;

    always_comb begin
        started_next = started_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        level_next   = level_reg;
        sol_next     = sol_reg;
        fin_next     = fin_reg;
        if (!fin_reg) begin
            // start phase shares the dwell counter
            if (!started_reg && (sample_mv < cfg.start_thr)) begin
                if (cnt_reg > START_TRIGGER) begin
                    started_next = 1'b1;
                    sol_next     = 1'b0;
                end else begin
                    cnt_next = bump(cnt_reg);
                end
            end
            if (range_now == last_reg) begin
                cnt_next = bump(cnt_next);
                if (cnt_next >= cfg.hold_count) begin
                    if (want == range_now) begin
                        level_next = level_inc;
                        if (level_inc >= LEVEL_DONE) begin
                            fin_next = 1'b1;
                        end else begin
                            cnt_next = '0;
                        end
                    end else begin
                        level_next = '0;
                        cnt_next   = '0;
                    end
                end
            end else begin
                last_next = range_now;
                cnt_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            cnt_reg     <= '0;
            last_reg    <= '0;
            level_reg   <= '0;
            sol_reg     <= 1'b1;
            fin_reg     <= 1'b0;
        end else if (step) begin
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
            last_reg    <= last_next;
            level_reg   <= level_next;
            sol_reg     <= sol_next;
            fin_reg     <= fin_next;
        end
    end

    assign status_next.led_level   = level_next;
    assign status_next.solenoid_on = sol_next;
    assign status_next.done        = fin_next;
    assign finished                = fin_reg;

endmodule

`default_nettype wire

FILE: verif/dwell_qualified_code_lock_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwell_qualified_code_lock_top_tb
// Self-checking bench for the dwell-qualified code lock.
//
// A directed table drives the start detection, the range thresholds, judging
// with zero and minimum hold counts, a full match/mismatch walk, crossed
// thresholds and writes to unused register indexes. Random phases follow.
// Each phase reprograms all registers and mostly sends dwell runs that aim at
// the next code entry. The last phase enters a complete code and checks that
// the lock then stays frozen. A behavioral lock model predicts every result
// word. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module dwell_qualified_code_lock_top_tb;

    import dqcl_pkg::*;

    localparam int MV_TOP        = (1 << MV_W) - 1;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_WORDS   = 150;

    // Indexes with no register behind them; writes there must be dropped.
    localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [RANGE_W-1:0] range_now;
        logic [TONE_W-1:0]  tone_hz;
        logic [LEVEL_W-1:0] led_level;
        logic               solenoid_on;
        logic               done_res;
    } lock_word_t;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [CFG_AW-1:0]  addr;    // unused on sample rows
        logic [CFG_DW-1:0]  value;   // sample in mV, or register data
        logic               typed;   // expected word written out below
        lock_word_t         word;
    } row_t;

    // Directed stimulus. Rows right after reset carry their expected word;
    // everything later is left to the lock model.
    localparam row_t DIRECTED [30] = '{
        // threshold edges at reset defaults
        '{ROW_SAMPLE, '0, 12'd0,    1'b1, '{RANGE_LOW,  TONE_LOW,  3'd0, 1'b1, 1'b0}},
        '{ROW_SAMPLE, '0, 12'hFFF,  1'b1, '{RANGE_HIGH, TONE_HIGH, 3'd0, 1'b1, 1'b0}},
        '{ROW_SAMPLE, '0, 12'd2000, 1'b1, '{RANGE_HIGH, TONE_HIGH, 3'd0, 1'b1, 1'b0}},
        '{ROW_SAMPLE, '0, 12'd1999, 1'b1, '{RANGE_MID,  TONE_MID,  3'd0, 1'b1, 1'b0}},
        '{ROW_SAMPLE, '0, 12'd1200, 1'b1, '{RANGE_MID,  TONE_MID,  3'd0, 1'b1, 1'b0}},
        '{ROW_SAMPLE, '0, 12'd1199, 1'b1, '{RANGE_LOW,  TONE_LOW,  3'd0, 1'b1, 1'b0}},
        // judge before start: hold of one, code 3,2,1,0 with junk above bit 7
        '{ROW_WRITE,  REG_HOLD_COUNT, 12'h001, 1'b0, '0},
        '{ROW_WRITE,  REG_CODE_WORD,  12'hF1B, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd1100, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd1100, 1'b0, '0},
        // zero hold: every repeat is judged; walk up to level 3, then miss
        '{ROW_WRITE,  REG_HOLD_COUNT, 12'h000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd1100, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd1500, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd1500, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd2500, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd2500, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd2500, 1'b0, '0},
        // start detection sharing the counter with the hold logic
        '{ROW_WRITE,  REG_HOLD_COUNT, 12'hFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd999,  1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd999,  1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd999,  1'b0, '0},
        '{ROW_SAMPLE, '0, 12'd999,  1'b0, '0},
        // crossed thresholds: upper wins, everything lands in range 1
        '{ROW_WRITE,  REG_UPPER_THR,  12'h000, 1'b0, '0},
        '{ROW_WRITE,  REG_LOWER_THR,  12'hFFF, 1'b0, '0},
        '{ROW_WRITE,  REG_START_THR,  12'hFFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'h555,  1'b0, '0},
        '{ROW_SAMPLE, '0, 12'hAAA,  1'b0, '0},
        // writes to unused indexes change nothing
        '{ROW_WRITE,  REG_SPARE_LO,   12'hFFF, 1'b0, '0},
        '{ROW_WRITE,  REG_SPARE_HI,   12'h000, 1'b0, '0},
        '{ROW_SAMPLE, '0, 12'hFFF,  1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [MV_W-1:0]    s_sample_mv;
    logic               m_valid;
    logic               m_ready;
    logic [RANGE_W-1:0] m_range_now;
    logic [TONE_W-1:0]  m_tone_hz;
    logic [LEVEL_W-1:0] m_led_level;
    logic               m_solenoid_on;
    logic               m_done_res;
    logic               cfg_wen;
    logic [CFG_AW-1:0]  cfg_addr;
    logic [CFG_DW-1:0]  cfg_wdata;

    dwell_qualified_code_lock_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_mv   (s_sample_mv),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_now   (m_range_now),
        .m_tone_hz     (m_tone_hz),
        .m_led_level   (m_led_level),
        .m_solenoid_on (m_solenoid_on),
        .m_done_res    (m_done_res),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // 20 ns clock, rising edge at 10 ns
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Lock model: register copies and lock state
    // ------------------------------------------------------------------------
    logic [7:0]         cfg_code;
    logic [CNT_W-1:0]   cfg_hold;
    logic [MV_W-1:0]    thr_start;
    logic [MV_W-1:0]    thr_upper;
    logic [MV_W-1:0]    thr_lower;

    logic               st_started;
    logic [CNT_W-1:0]   st_count;
    logic [RANGE_W-1:0] st_last;
    logic [LEVEL_W-1:0] st_level;
    logic               st_solenoid;
    logic               st_finished;

    lock_word_t lock_expected[$];

    bit idle_on;         // random idling on both channels
    int n_fail;
    int n_samples_sent;
    int n_words_checked;
    int n_entry_hits;
    int n_entry_misses;

    function automatic logic [RANGE_W-1:0] sort_range(input logic [MV_W-1:0] mv);
        if (mv >= thr_upper) return RANGE_HIGH;
        if (mv >= thr_lower) return RANGE_MID;
        return RANGE_LOW;
    endfunction

    function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    endfunction

    // Draw a sample that lands in range r under the current thresholds;
    // fall back to any sample if that range is empty.
    function automatic logic [MV_W-1:0] mv_for_range(input logic [RANGE_W-1:0] r);
        logic [MV_W-1:0] floor_thr;
        floor_thr = (thr_lower < thr_upper) ? thr_lower : thr_upper;
        case (r)
            RANGE_HIGH: begin
                return MV_W'($urandom_range(thr_upper, MV_TOP));
            end
            RANGE_MID: begin
                if (thr_lower < thr_upper)
                    return MV_W'($urandom_range(thr_lower, thr_upper - 1));
            end
            default: begin
                if (floor_thr != 0)
                    return MV_W'($urandom_range(0, floor_thr - 1));
            end
        endcase
        return MV_W'($urandom_range(0, MV_TOP));
    endfunction

    task automatic lock_reset();
        cfg_code    = CODE_WORD_RST;
        cfg_hold    = HOLD_COUNT_RST;
        thr_start   = START_THR_RST;
        thr_upper   = UPPER_THR_RST;
        thr_lower   = LOWER_THR_RST;
        st_started  = 1'b0;
        st_count    = '0;
        st_last     = '0;
        st_level    = '0;
        st_solenoid = 1'b1;
        st_finished = 1'b0;
    endtask

    // Advance the lock model by one sample and return the word it should give.
    task automatic lock_advance(input logic [MV_W-1:0] mv, output lock_word_t w);
        logic [RANGE_W-1:0] r;
        logic [1:0]         idx;
        logic [1:0]         want;
        r = sort_range(mv);
        if (!st_finished) begin
            // start phase: low samples bump the shared counter until it passes 2
            if (!st_started && mv < thr_start) begin
                if (st_count > START_TRIGGER) begin
                    st_started  = 1'b1;
                    st_solenoid = 1'b0;
                end else begin
                    st_count = count_up(st_count);
                end
            end
            // hold phase: judge a held range against the next code entry
            if (r == st_last) begin
                st_count = count_up(st_count);
                if (st_count >= cfg_hold) begin
                    idx  = st_level[1:0];
                    want = cfg_code[2*idx +: 2];
                    if (want == r) begin
                        st_level = st_level + 1'b1;
                        n_entry_hits++;
                        if (st_level >= CODE_LENGTH_DEF)
                            st_finished = 1'b1;
                        else
                            st_count = '0;
                    end else begin
                        st_level = '0;
                        st_count = '0;
                        n_entry_misses++;
                    end
                end
            end else begin
                st_last  = r;
                st_count = '0;
            end
        end
        w.range_now   = r;
        case (r)
            RANGE_HIGH: w.tone_hz = TONE_HIGH;
            RANGE_MID:  w.tone_hz = TONE_MID;
            default:    w.tone_hz = TONE_LOW;
        endcase
        w.led_level   = st_level;
        w.solenoid_on = st_solenoid;
        w.done_res    = st_finished;
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Register write; cfg_wen is dropped by whatever comes next.
    task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
        cfg_wen   <= 1'b1;
        cfg_addr  <= a;
        cfg_wdata <= d;
        @(posedge aclk);
        case (a)
            REG_CODE_WORD:  cfg_code  = d[7:0];
            REG_HOLD_COUNT: cfg_hold  = d[CNT_W-1:0];
            REG_START_THR:  thr_start = d;
            REG_UPPER_THR:  thr_upper = d;
            REG_LOWER_THR:  thr_lower = d;
            default: ;
        endcase
    endtask

    // Offer one sample word, hold it until accepted, then queue its prediction.
    task automatic send_sample(input logic [MV_W-1:0] mv, input logic typed,
                               input lock_word_t typed_word);
        lock_word_t w;
        if (cfg_wen)
            cfg_wen <= 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_mv <= mv;
        do @(posedge aclk); while (!s_ready);
        lock_advance(mv, w);
        lock_expected.push_back(typed ? typed_word : w);
        n_samples_sent++;
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (lock_expected.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Receiver back-pressure: random stall bursts while idling is on.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        lock_word_t exp_w;
        if (aresetn && m_valid && m_ready) begin
            if (lock_expected.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("[%0t] unexpected result word: range %0d tone %0d level %0d",
                             $realtime, m_range_now, m_tone_hz, m_led_level);
            end else begin
                exp_w = lock_expected.pop_front();
                n_words_checked++;
                if (m_range_now   !== exp_w.range_now   ||
                    m_tone_hz     !== exp_w.tone_hz     ||
                    m_led_level   !== exp_w.led_level   ||
                    m_solenoid_on !== exp_w.solenoid_on ||
                    m_done_res    !== exp_w.done_res) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display({"[%0t] word %0d mismatch: exp range %0d tone %0d level %0d ",
                                  "sol %0b done %0b / got range %0d tone %0d level %0d ",
                                  "sol %0b done %0b"},
                                 $realtime, n_words_checked, exp_w.range_now, exp_w.tone_hz,
                                 exp_w.led_level, exp_w.solenoid_on, exp_w.done_res,
                                 m_range_now, m_tone_hz, m_led_level, m_solenoid_on,
                                 m_done_res);
                end
            end
        end
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("timeout with %0d result words outstanding", lock_expected.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        row_t               row;
        logic               prev_sample;
        logic [RANGE_W-1:0] want;
        logic [RANGE_W-1:0] r;
        logic [7:0]         code;
        logic [CNT_W-1:0]   hold;
        logic [MV_W-1:0]    lo_thr;
        logic [MV_W-1:0]    up_thr;
        int                 sent;
        int                 len;
        int                 sel;
        int                 k;
        int                 runs;

        // drive every input to a known value before the first edge
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_sample_mv = '0;
        cfg_wen     = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        idle_on     = 1'b1;
        n_fail          = 0;
        n_samples_sent  = 0;
        n_words_checked = 0;
        n_entry_hits    = 0;
        n_entry_misses  = 0;
        prev_sample     = 1'b0;
        lock_reset();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed table; drain before every write that follows samples
        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            if (row.kind == ROW_WRITE) begin
                if (prev_sample)
                    drain();
                write_reg(row.addr, row.value);
                prev_sample = 1'b0;
            end else begin
                send_sample(row.value, row.typed, row.word);
                prev_sample = 1'b1;
            end
        end

        // Random phases. Each code word keeps one empty entry past the first,
        // so the lock climbs and falls but never opens before the last phase.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            code = 8'($urandom_range(0, 255));
            k    = $urandom_range(1, 3);
            code = code & ~(8'h3 << (2 * k));
            case (ph)
                0:       hold = '0;
                1:       hold = CNT_MAX;
                default: hold = CNT_W'($urandom_range(1, 8));
            endcase
            case (ph)
                2: begin                      // crossed thresholds
                    up_thr = MV_W'($urandom_range(0, 2000));
                    lo_thr = MV_W'($urandom_range(up_thr + 1, MV_TOP));
                end
                3: begin                      // widest spread
                    lo_thr = '0;
                    up_thr = MV_W'(MV_TOP);
                end
                default: begin
                    lo_thr = MV_W'($urandom_range(1, 4000));
                    up_thr = MV_W'($urandom_range(lo_thr + 1, MV_TOP));
                end
            endcase
            write_reg(REG_CODE_WORD,  {4'($urandom_range(0, 15)), code});
            write_reg(REG_HOLD_COUNT, {4'($urandom_range(0, 15)), hold});
            write_reg(REG_START_THR,  MV_W'($urandom_range(0, MV_TOP)));
            write_reg(REG_UPPER_THR,  up_thr);
            write_reg(REG_LOWER_THR,  lo_thr);
            idle_on = ($urandom_range(0, 3) != 0);

            sent = 0;
            while (sent < PHASE_WORDS) begin
                want = cfg_code[2*st_level[1:0] +: 2];
                if (want == '0)
                    want = RANGE_W'($urandom_range(1, 3));
                sel = $urandom_range(0, 19);
                len = int'(cfg_hold) + 1 + $urandom_range(0, 1);
                if (sel < 14) begin
                    // dwell on the entry the lock waits for
                    for (int n = 0; n < len; n++)
                        send_sample(mv_for_range(want), 1'b0, '0);
                end else if (sel < 17) begin
                    // dwell on a wrong range
                    r = RANGE_W'((want % 3) + 1);
                    for (int n = 0; n < len; n++)
                        send_sample(mv_for_range(r), 1'b0, '0);
                end else begin
                    // short noise burst
                    len = $urandom_range(1, 3);
                    for (int n = 0; n < len; n++)
                        send_sample(MV_W'($urandom_range(0, MV_TOP)), 1'b0, '0);
                end
                sent += len;
            end
        end

        // Last phase, no idling: enter a full code, then confirm the freeze.
        drain();
        idle_on = 1'b0;
        code = {2'($urandom_range(1, 3)), 2'($urandom_range(1, 3)),
                2'($urandom_range(1, 3)), 2'($urandom_range(1, 3))};
        lo_thr = MV_W'($urandom_range(1, 3000));
        up_thr = MV_W'($urandom_range(lo_thr + 1, MV_TOP));
        write_reg(REG_CODE_WORD,  {4'h0, code});
        write_reg(REG_HOLD_COUNT, {4'h0, CNT_W'($urandom_range(1, 6))});
        write_reg(REG_START_THR,  MV_W'($urandom_range(0, MV_TOP)));
        write_reg(REG_UPPER_THR,  up_thr);
        write_reg(REG_LOWER_THR,  lo_thr);
        runs = 0;
        while (!st_finished && runs < 12) begin
            want = cfg_code[2*st_level[1:0] +: 2];
            len  = int'(cfg_hold) + 1;
            for (int n = 0; n < len; n++)
                send_sample(mv_for_range(want), 1'b0, '0);
            runs++;
        end
        for (int n = 0; n < 40; n++)
            send_sample(MV_W'($urandom_range(0, MV_TOP)), 1'b0, '0);

        drain();
        repeat (8) @(posedge aclk);

        $display("Run covered %0d sample words and %0d checked result words",
                 n_samples_sent, n_words_checked);
        $display("Code entries judged: %0d matched, %0d missed; lock %s at the end",
                 n_entry_hits, n_entry_misses, st_finished ? "open" : "closed");
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d result words failed", n_fail);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/dqcl_pkg.sv
hdl/dqcl_classify.sv
hdl/dqcl_core.sv
hdl/dwell_qualified_code_lock_top.sv
verif/dwell_qualified_code_lock_top_tb.sv
